// ===== src/d2vh_pkg.sv =====
// Shared constants for the dual two-dimensional variable-edge histogram.
`default_nettype none

package d2vh_pkg;

    // Default geometry and counter width.
    localparam int DEF_Q2_BIN_COUNT = 8;
    localparam int DEF_X_BIN_COUNT  = 8;
    localparam int DEF_COUNT_BITS   = 32;

    // Width of every Q16.16 value and bin edge.
    localparam int VALUE_W = 32;

    // Request kinds carried on tuser.
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_EVENT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_Q2_EDGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_X_EDGE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd3;

    // Counter selection in read requests.
    localparam int SEL_W = 2;

    // Input tdata layout, lowest bit first.
    localparam int OFF_RECO_Q2     = 0;
    localparam int OFF_RECO_X      = 32;
    localparam int OFF_TRUE_Q2     = 64;
    localparam int OFF_TRUE_X      = 96;
    localparam int OFF_SPIN        = 128;
    localparam int OFF_EDGE_INDEX  = 129;
    localparam int EDGE_INDEX_W    = 4;
    localparam int OFF_EDGE_VALUE  = 133;
    localparam int OFF_READ_SELECT = 165;
    localparam int OFF_READ_Q2_BIN = 167;
    localparam int OFF_READ_X_BIN  = 170;
    localparam int READ_BIN_W      = 3;
    localparam int S_TDATA_W       = 176;

    // Output tdata layout, lowest bit first.
    localparam int OUT_IDX_W      = 3;
    localparam int EVENT_BITS_W   = 14;
    localparam int READ_COUNT_W   = 32;
    localparam int M_TDATA_W      = 48;
    localparam int OFF_RECO_HIT   = 0;
    localparam int OFF_TRUE_HIT   = 7;

endpackage

`default_nettype wire

// ===== src/d2vh_bin_find.sv =====
// Parallel edge comparators that find the lowest bin holding a value.
`default_nettype none

module d2vh_bin_find #(
    parameter int N  = d2vh_pkg::DEF_Q2_BIN_COUNT,
    parameter int IW = (N > 1) ? $clog2(N) : 1
) (
    input  logic [N:0][d2vh_pkg::VALUE_W-1:0] i_edges,
    input  logic [d2vh_pkg::VALUE_W-1:0]      i_value,
    output logic                              o_hit,
    output logic [IW-1:0]                     o_index
);
    import d2vh_pkg::*;

    logic [N-1:0] w_match;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_match[i] = (i_value >= i_edges[i]) && (i_value < i_edges[i + 1]);
        end
    end

    // Scan from the top down so that the lowest matching bin wins.
    always_comb begin
        o_hit   = 1'b0;
        o_index = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                o_hit   = 1'b1;
                o_index = IW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/d2vh_count_mem.sv =====
// Counter memory with one write port and one registered read port.
`default_nettype none

module d2vh_count_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = d2vh_pkg::DEF_COUNT_BITS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    import d2vh_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read-before-write: a read of the entry being written returns the old value.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/dual_2d_variable_edge_histogram.sv =====
// Top level of the dual two-dimensional histogram with programmable bin edges.
`default_nettype none

// Two 2D histograms, one filled from the reconstructed (Q2, x) pair and one
// from the generated pair, share one table of Q2 bin edges and one table of
// x bin edges. A value v lies in bin i when edge[i] <= v < edge[i+1]; values
// outside the edges are not counted, and with non-monotone edges only the
// lowest matching bin is used. Each histogram keeps separate counters for
// spin up and spin down, and every counter saturates. A request is an event,
// a Q2-edge write, an x-edge write or a counter read, selected by tuser, and
// every request returns exactly one result. The block accepts one request
// per clock cycle while the output is not stalled and presents its result
// in the output register: edges are compared in the cycle of acceptance,
// stage 1 reads the counter memories, and stage 2 increments, writes back
// and loads the output register. Each histogram lives in one memory with a
// single read and a single write port, so the increment of a counter is
// split over the read and write-back stages; back-to-back hits on the same
// counter are handled by forwarding the value just written. After reset the
// block clears all 2 * Q2_BIN_COUNT * X_BIN_COUNT entries (128 at the default
// size) of both memories, one entry per cycle, and accepts no request
// meanwhile. Edge tables reset to zero. A stalled output holds the pipeline.

module dual_2d_variable_edge_histogram #(
    parameter int Q2_BIN_COUNT = d2vh_pkg::DEF_Q2_BIN_COUNT,
    parameter int X_BIN_COUNT  = d2vh_pkg::DEF_X_BIN_COUNT,
    parameter int COUNT_BITS   = d2vh_pkg::DEF_COUNT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Fields from bit 0 up: reco_q2, reco_x, true_q2, true_x, spin_positive,
    // edge_index, edge_value, read_select, read_q2_bin, read_x_bin, zero fill.
    input  logic [d2vh_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0 up: mode.
    input  logic [d2vh_pkg::MODE_W-1:0]      s_axis_tuser,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0 up: reco_hit, reco_q2_index, reco_x_index, true_hit,
    // true_q2_index, true_x_index, read_count, zero fill.
    output logic [d2vh_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready
);
    import d2vh_pkg::*;

    localparam int CELLS     = Q2_BIN_COUNT * X_BIN_COUNT;
    localparam int MEM_DEPTH = 2 * CELLS;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int QW        = (Q2_BIN_COUNT > 1) ? $clog2(Q2_BIN_COUNT) : 1;
    localparam int XW        = (X_BIN_COUNT > 1) ? $clog2(X_BIN_COUNT) : 1;
    localparam logic [AW-1:0] CELLS_A = AW'(CELLS);
    localparam logic [AW-1:0] XCNT_A  = AW'(X_BIN_COUNT);
    localparam logic [AW-1:0] LAST_A  = AW'(MEM_DEPTH - 1);

    // ------------------------------------------------------------------
    // Request fields.
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]       in_mode;
    logic [VALUE_W-1:0]      in_reco_q2;
    logic [VALUE_W-1:0]      in_reco_x;
    logic [VALUE_W-1:0]      in_true_q2;
    logic [VALUE_W-1:0]      in_true_x;
    logic                    in_spin;
    logic [EDGE_INDEX_W-1:0] in_edge_index;
    logic [VALUE_W-1:0]      in_edge_value;
    logic [SEL_W-1:0]        in_sel;
    logic [READ_BIN_W-1:0]   in_rq_bin;
    logic [READ_BIN_W-1:0]   in_rx_bin;
    logic                    accept;
    logic                    adv;

    assign in_mode       = s_axis_tuser;
    assign in_reco_q2    = s_axis_tdata[OFF_RECO_Q2 +: VALUE_W];
    assign in_reco_x     = s_axis_tdata[OFF_RECO_X +: VALUE_W];
    assign in_true_q2    = s_axis_tdata[OFF_TRUE_Q2 +: VALUE_W];
    assign in_true_x     = s_axis_tdata[OFF_TRUE_X +: VALUE_W];
    assign in_spin       = s_axis_tdata[OFF_SPIN];
    assign in_edge_index = s_axis_tdata[OFF_EDGE_INDEX +: EDGE_INDEX_W];
    assign in_edge_value = s_axis_tdata[OFF_EDGE_VALUE +: VALUE_W];
    assign in_sel        = s_axis_tdata[OFF_READ_SELECT +: SEL_W];
    assign in_rq_bin     = s_axis_tdata[OFF_READ_Q2_BIN +: READ_BIN_W];
    assign in_rx_bin     = s_axis_tdata[OFF_READ_X_BIN +: READ_BIN_W];

    // ------------------------------------------------------------------
    // Clearing pass over both counter memories after reset.
    // ------------------------------------------------------------------
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_A) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // The whole pipeline moves whenever the output register can take a result.
    logic r_out_valid;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv && !r_clr_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Edge tables. A write takes effect for the very next request.
    // ------------------------------------------------------------------
    logic [Q2_BIN_COUNT:0][VALUE_W-1:0] r_q2_edges;
    logic [X_BIN_COUNT:0][VALUE_W-1:0]  r_x_edges;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q2_edges <= '0;
            r_x_edges  <= '0;
        end else if (accept) begin
            // Indexes beyond the table match no entry and are dropped.
            for (int i = 0; i <= Q2_BIN_COUNT; i++) begin
                if (in_mode == MODE_Q2_EDGE &&
                    {28'd0, in_edge_index} == 32'(i)) begin
                    r_q2_edges[i] <= in_edge_value;
                end
            end
            for (int i = 0; i <= X_BIN_COUNT; i++) begin
                if (in_mode == MODE_X_EDGE &&
                    {28'd0, in_edge_index} == 32'(i)) begin
                    r_x_edges[i] <= in_edge_value;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: bin search on the incoming request.
    // ------------------------------------------------------------------
    logic          reco_q_hit;
    logic          reco_x_hit;
    logic          true_q_hit;
    logic          true_x_hit;
    logic [QW-1:0] reco_q_idx;
    logic [XW-1:0] reco_x_idx;
    logic [QW-1:0] true_q_idx;
    logic [XW-1:0] true_x_idx;

    d2vh_bin_find #(.N(Q2_BIN_COUNT), .IW(QW)) u_reco_q2_find (
        .i_edges (r_q2_edges),
        .i_value (in_reco_q2),
        .o_hit   (reco_q_hit),
        .o_index (reco_q_idx)
    );

    d2vh_bin_find #(.N(X_BIN_COUNT), .IW(XW)) u_reco_x_find (
        .i_edges (r_x_edges),
        .i_value (in_reco_x),
        .o_hit   (reco_x_hit),
        .o_index (reco_x_idx)
    );

    d2vh_bin_find #(.N(Q2_BIN_COUNT), .IW(QW)) u_true_q2_find (
        .i_edges (r_q2_edges),
        .i_value (in_true_q2),
        .o_hit   (true_q_hit),
        .o_index (true_q_idx)
    );

    d2vh_bin_find #(.N(X_BIN_COUNT), .IW(XW)) u_true_x_find (
        .i_edges (r_x_edges),
        .i_value (in_true_x),
        .o_hit   (true_x_hit),
        .o_index (true_x_idx)
    );

    logic                    n_reco_inc;
    logic                    n_true_inc;
    logic                    n_rd_ok;
    logic [AW-1:0]           slot_base;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           n_reco_addr;
    logic [AW-1:0]           n_true_addr;
    logic [EVENT_BITS_W-1:0] n_event_bits;

    always_comb begin
        // Spin up lands in the first half of each memory, spin down in the second.
        slot_base  = in_spin ? '0 : CELLS_A;
        n_reco_inc = (in_mode == MODE_EVENT) && reco_q_hit && reco_x_hit;
        n_true_inc = (in_mode == MODE_EVENT) && true_q_hit && true_x_hit;

        n_rd_ok = (in_mode == MODE_READ) &&
                  ({4'd0, in_rq_bin} < 7'(Q2_BIN_COUNT)) &&
                  ({4'd0, in_rx_bin} < 7'(X_BIN_COUNT));
        rd_addr = (in_sel[0] ? CELLS_A : '0) +
                  AW'(AW'(in_rq_bin) * XCNT_A) + AW'(in_rx_bin);

        if (in_mode == MODE_READ) begin
            n_reco_addr = rd_addr;
            n_true_addr = rd_addr;
        end else begin
            n_reco_addr = slot_base + AW'(AW'(reco_q_idx) * XCNT_A) + AW'(reco_x_idx);
            n_true_addr = slot_base + AW'(AW'(true_q_idx) * XCNT_A) + AW'(true_x_idx);
        end

        // A partial match reports no hit and zero indexes.
        n_event_bits = '0;
        if (n_reco_inc) begin
            n_event_bits[OFF_RECO_HIT]                = 1'b1;
            n_event_bits[OFF_RECO_HIT + 1 +: OUT_IDX_W] = OUT_IDX_W'(reco_q_idx);
            n_event_bits[OFF_RECO_HIT + 4 +: OUT_IDX_W] = OUT_IDX_W'(reco_x_idx);
        end
        if (n_true_inc) begin
            n_event_bits[OFF_TRUE_HIT]                = 1'b1;
            n_event_bits[OFF_TRUE_HIT + 1 +: OUT_IDX_W] = OUT_IDX_W'(true_q_idx);
            n_event_bits[OFF_TRUE_HIT + 4 +: OUT_IDX_W] = OUT_IDX_W'(true_x_idx);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: counter memory read. Stage 2: increment and write back.
    // ------------------------------------------------------------------
    logic                    r_s1_valid;
    logic                    r_s1_reco_inc;
    logic                    r_s1_true_inc;
    logic                    r_s1_rd_ok;
    logic                    r_s1_rd_true;
    logic [AW-1:0]           r_s1_reco_addr;
    logic [AW-1:0]           r_s1_true_addr;
    logic [EVENT_BITS_W-1:0] r_s1_event_bits;

    logic                    r_s2_valid;
    logic                    r_s2_reco_inc;
    logic                    r_s2_true_inc;
    logic                    r_s2_rd_ok;
    logic                    r_s2_rd_true;
    logic [AW-1:0]           r_s2_reco_addr;
    logic [AW-1:0]           r_s2_true_addr;
    logic [EVENT_BITS_W-1:0] r_s2_event_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_reco_inc   <= n_reco_inc;
            r_s1_true_inc   <= n_true_inc;
            r_s1_rd_ok      <= n_rd_ok;
            r_s1_rd_true    <= in_sel[1];
            r_s1_reco_addr  <= n_reco_addr;
            r_s1_true_addr  <= n_true_addr;
            r_s1_event_bits <= n_event_bits;

            r_s2_reco_inc   <= r_s1_reco_inc;
            r_s2_true_inc   <= r_s1_true_inc;
            r_s2_rd_ok      <= r_s1_rd_ok;
            r_s2_rd_true    <= r_s1_rd_true;
            r_s2_reco_addr  <= r_s1_reco_addr;
            r_s2_true_addr  <= r_s1_true_addr;
            r_s2_event_bits <= r_s1_event_bits;
        end
    end

    logic [COUNT_BITS-1:0] reco_rdata;
    logic [COUNT_BITS-1:0] true_rdata;
    logic [COUNT_BITS-1:0] reco_cur;
    logic [COUNT_BITS-1:0] true_cur;
    logic [COUNT_BITS-1:0] reco_next;
    logic [COUNT_BITS-1:0] true_next;
    logic                  reco_upd;
    logic                  true_upd;
    logic                  reco_we;
    logic                  true_we;
    logic [AW-1:0]         reco_waddr;
    logic [AW-1:0]         true_waddr;
    logic [COUNT_BITS-1:0] reco_wdata;
    logic [COUNT_BITS-1:0] true_wdata;

    // Forwarding: the request right behind a write read the entry before that
    // write took effect, so it takes the value just written instead.
    logic                  r_reco_fwd;
    logic                  r_true_fwd;
    logic [COUNT_BITS-1:0] r_reco_fwd_data;
    logic [COUNT_BITS-1:0] r_true_fwd_data;

    assign reco_cur  = r_reco_fwd ? r_reco_fwd_data : reco_rdata;
    assign true_cur  = r_true_fwd ? r_true_fwd_data : true_rdata;
    assign reco_next = (&reco_cur) ? reco_cur : reco_cur + COUNT_BITS'(1);
    assign true_next = (&true_cur) ? true_cur : true_cur + COUNT_BITS'(1);

    assign reco_upd = adv && r_s2_valid && r_s2_reco_inc;
    assign true_upd = adv && r_s2_valid && r_s2_true_inc;

    assign reco_we    = r_clr_busy || reco_upd;
    assign true_we    = r_clr_busy || true_upd;
    assign reco_waddr = r_clr_busy ? r_clr_addr : r_s2_reco_addr;
    assign true_waddr = r_clr_busy ? r_clr_addr : r_s2_true_addr;
    assign reco_wdata = r_clr_busy ? '0 : reco_next;
    assign true_wdata = r_clr_busy ? '0 : true_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reco_fwd <= 1'b0;
            r_true_fwd <= 1'b0;
        end else if (adv) begin
            r_reco_fwd <= reco_upd && (r_s2_reco_addr == r_s1_reco_addr);
            r_true_fwd <= true_upd && (r_s2_true_addr == r_s1_true_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_reco_fwd_data <= reco_next;
            r_true_fwd_data <= true_next;
        end
    end

    d2vh_count_mem #(.DEPTH(MEM_DEPTH), .WIDTH(COUNT_BITS), .AW(AW)) u_reco_mem (
        .i_clk   (i_clk),
        .i_we    (reco_we),
        .i_waddr (reco_waddr),
        .i_wdata (reco_wdata),
        .i_re    (adv),
        .i_raddr (r_s1_reco_addr),
        .o_rdata (reco_rdata)
    );

    d2vh_count_mem #(.DEPTH(MEM_DEPTH), .WIDTH(COUNT_BITS), .AW(AW)) u_true_mem (
        .i_clk   (i_clk),
        .i_we    (true_we),
        .i_waddr (true_waddr),
        .i_wdata (true_wdata),
        .i_re    (adv),
        .i_raddr (r_s1_true_addr),
        .o_rdata (true_rdata)
    );

    // ------------------------------------------------------------------
    // Result assembly and output register.
    // ------------------------------------------------------------------
    logic [COUNT_BITS-1:0]   rd_cur;
    logic [63:0]             rd_wide;
    logic [READ_COUNT_W-1:0] read_count;
    logic [M_TDATA_W-1:0]    r_out_data;

    always_comb begin
        rd_cur  = r_s2_rd_true ? true_cur : reco_cur;
        rd_wide = 64'(rd_cur);
        // Counters wider than the result field clip to its maximum.
        if (!r_s2_rd_ok) begin
            read_count = '0;
        end else if (|rd_wide[63:READ_COUNT_W]) begin
            read_count = '1;
        end else begin
            read_count = rd_wide[READ_COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {(M_TDATA_W - EVENT_BITS_W - READ_COUNT_W)'(0),
                           read_count, r_s2_event_bits};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Forwarding is only ever armed by a counter write of the step that
    // loaded it; during a stall it simply holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_reco_fwd && $past(adv)) |-> $past(reco_upd))
        else $error("reco forwarding without a preceding write");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_true_fwd && $past(adv)) |-> $past(true_upd))
        else $error("true forwarding without a preceding write");

    // No counter update may compete with the clearing pass.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !(r_s1_valid || r_s2_valid || r_out_valid))
        else $error("request in flight during clearing pass");

    // An event hit and a nonzero read count never share one result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[OFF_RECO_HIT] || m_axis_tdata[OFF_TRUE_HIT]))
        |-> (m_axis_tdata[EVENT_BITS_W +: READ_COUNT_W] == '0))
        else $error("event result carries a read count");

endmodule

`default_nettype wire
